### sv/pbcd_pkg.sv
package pbcd_pkg;

    localparam int WORD_BYTES = 8;
    localparam int IN_W       = 64;
    localparam int DATA_W     = 8 * WORD_BYTES;
    localparam int NIBS       = 2 * WORD_BYTES;
    localparam int NIB_CNT_W  = $clog2(NIBS + 1);
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CODE_MINUS = CHAR_W'(45);
    localparam logic [3:0]        SIGN_NIB   = 4'hF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic shift_byte;
        logic shift_nib;
    } ctrl_t;

    typedef struct packed {
        logic                 top_byte_zero;
        logic [3:0]           top_nib;
        logic [NIB_CNT_W-1:0] nib_left;
    } status_t;

endpackage

### sv/pbcd_shifter.sv
module pbcd_shifter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pbcd_pkg::IN_W-1:0]   bcd_word,
    input  pbcd_pkg::ctrl_t             ctrl,
    output pbcd_pkg::status_t           status
);
    import pbcd_pkg::*;

    logic [DATA_W-1:0]    data_reg;
    logic [DATA_W-1:0]    data_next;
    logic [NIB_CNT_W-1:0] nib_left_reg;
    logic [NIB_CNT_W-1:0] nib_left_next;

    always_comb
    begin
        data_next     = data_reg;
        nib_left_next = nib_left_reg;
        if (ctrl.load)
        begin
            data_next     = bcd_word[DATA_W-1:0];
            nib_left_next = NIB_CNT_W'(NIBS);
        end
        else if (ctrl.shift_byte)
        begin
            data_next     = data_reg << 8;
            nib_left_next = nib_left_reg - NIB_CNT_W'(2);
        end
        else if (ctrl.shift_nib)
        begin
            data_next     = data_reg << 4;
            nib_left_next = nib_left_reg - NIB_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nib_left_reg <= '0;
        end
        else
        begin
            nib_left_reg <= nib_left_next;
        end
    end

    assign status.top_byte_zero = (data_reg[DATA_W-1 -: 8] == 8'h00);
    assign status.top_nib       = data_reg[DATA_W-1 -: 4];
    assign status.nib_left      = nib_left_reg;

endmodule

### sv/pbcd_ctrl.sv
module pbcd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pbcd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char,
    input  pbcd_pkg::status_t             status,
    output pbcd_pkg::ctrl_t               ctrl
);
    import pbcd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic              signed_mode_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              slot_free;
    logic [CHAR_W-1:0] digit_code;

    assign slot_free  = !out_valid_reg || out_ready;
    assign digit_code = CODE_ZERO + {{(CHAR_W-4){1'b0}}, status.top_nib};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            signed_mode_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                signed_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ctrl            = '0;
        in_ready        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        char_next       = char_reg;
        last_next       = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.top_byte_zero && status.nib_left > NIB_CNT_W'(2))
                begin
                    ctrl.shift_byte = 1'b1;
                end
                else
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (status.top_nib == 4'h0)
                begin
                    ctrl.shift_nib = 1'b1;
                    state_next     = ST_DIGITS;
                end
                else if (slot_free)
                begin
                    ctrl.shift_nib = 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    char_next      = (signed_mode_reg && status.top_nib == SIGN_NIB)
                                     ? CODE_MINUS : digit_code;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (slot_free)
                begin
                    ctrl.shift_nib = 1'b1;
                    out_valid_next = 1'b1;
                    char_next      = digit_code;
                    last_next      = (status.nib_left == NIB_CNT_W'(1));
                    if (status.nib_left == NIB_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

### sv/packed_bcd_to_digit_chars_core.sv
// After an input transfer the word is loaded and zero top bytes are skipped one byte at a time;
// the top tens digit is then output as a digit (or a minus sign in signed mode), or dropped when zero.
// Throughput: one character per cycle while out_ready is held high; the nibble shift register
// moves one nibble per character.
// A new word is taken only after the last character of the previous one is staged.
// Reset (rst_n low, asynchronous) clears signed_mode, the state and the output valid.
module packed_bcd_to_digit_chars_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pbcd_pkg::IN_W-1:0]     bcd_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pbcd_pkg::CHAR_W-1:0]   char_code,
    output logic                          last_char
);
    import pbcd_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    pbcd_shifter u_shifter (
        .clk      (clk),
        .rst_n    (rst_n),
        .bcd_word (bcd_word),
        .ctrl     (ctrl),
        .status   (status)
    );

    pbcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char),
        .status    (status),
        .ctrl      (ctrl)
    );

endmodule

### sv/pbcd_checker.sv
module pbcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pbcd_pkg::CHAR_W-1:0]   char_code,
    input logic                          last_char
);
    import pbcd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
        else $error("output changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == CODE_MINUS || char_code >= CODE_ZERO))
        else $error("character code out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    a_no_accept_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_char |-> !in_ready)
        else $error("input ready before the last character");

endmodule

bind packed_bcd_to_digit_chars_core pbcd_checker u_pbcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
);

### dv/packed_bcd_to_digit_chars_checker.sv
module packed_bcd_to_digit_chars_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [pbcd_pkg::IN_W-1:0]     bcd_word,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [pbcd_pkg::CHAR_W-1:0]   char_code,
    input  logic                          last_char,
    output int                            fail_count,
    output int                            pending_count,
    output int                            checked_count
);

    typedef struct packed {
        logic [pbcd_pkg::CHAR_W-1:0] code;
        logic                        last;
    } digit_char_t;

    digit_char_t char_queue[$];
    digit_char_t want;
    logic        signed_sel;
    int          errors  = 0;
    int          pending = 0;
    int          checked = 0;

    assign fail_count    = errors;
    assign pending_count = pending;
    assign checked_count = checked;

    function automatic void push_char(input logic [pbcd_pkg::CHAR_W-1:0] code);
        digit_char_t c;
        c.code = code;
        c.last = 1'b0;
        char_queue.push_back(c);
    endfunction

    function automatic void predict_chars(input logic [pbcd_pkg::IN_W-1:0] word);
        int         nbytes;
        int         top;
        int         b;
        logic       any;
        logic [7:0] cur_byte;
        logic [3:0] tens;
        logic [3:0] ones;
        nbytes = pbcd_pkg::WORD_BYTES;
        if (nbytes < 1) nbytes = 1;
        if (nbytes > 8) nbytes = 8;
        top = 0;
        any = 1'b0;
        for (b = 0; b < nbytes; b++) begin
            if (word[8*b +: 8] != 8'h00) begin
                top = b;
                any = 1'b1;
            end
        end
        if (!any) begin
            push_char(pbcd_pkg::CODE_ZERO);
        end
        else begin
            for (b = top; b >= 0; b--) begin
                cur_byte = word[8*b +: 8];
                tens     = cur_byte[7:4];
                ones     = cur_byte[3:0];
                if (b == top) begin
                    if (signed_sel && tens == pbcd_pkg::SIGN_NIB)
                        push_char(pbcd_pkg::CODE_MINUS);
                    else if (tens != 4'h0)
                        push_char(pbcd_pkg::CODE_ZERO + {2'b00, tens});
                end
                else begin
                    push_char(pbcd_pkg::CODE_ZERO + {2'b00, tens});
                end
                push_char(pbcd_pkg::CODE_ZERO + {2'b00, ones});
            end
        end
        char_queue[char_queue.size()-1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            signed_sel = 1'b0;
            char_queue.delete();
            pending = 0;
        end
        else begin
            if (cfg_we)
                signed_sel = cfg_wdata;
            if (in_valid && in_ready)
                predict_chars(bcd_word);
            if (out_valid && out_ready) begin
                if (char_queue.size() == 0) begin
                    $display("%0t: unexpected char transfer: code %0d last %0b",
                             $time, char_code, last_char);
                    errors++;
                end
                else begin
                    want = char_queue.pop_front();
                    checked++;
                    if (char_code !== want.code) begin
                        $display("%0t: char_code mismatch: expected %0d actual %0d",
                                 $time, want.code, char_code);
                        errors++;
                    end
                    if (last_char !== want.last) begin
                        $display("%0t: last_char mismatch: expected %0b actual %0b",
                                 $time, want.last, last_char);
                        errors++;
                    end
                end
            end
            pending = char_queue.size();
        end
    end

endmodule

### dv/packed_bcd_to_digit_chars_core_tb.sv
module packed_bcd_to_digit_chars_core_tb;

    localparam int MAX_CYCLES = 1500000;
    localparam int HOLD_OFF   = 200;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic                        cfg_wdata = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [pbcd_pkg::IN_W-1:0]   bcd_word  = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [pbcd_pkg::CHAR_W-1:0] char_code;
    logic                        last_char;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycles       = 0;
    int words_sent   = 0;
    int signed_words = 0;
    bit quiet        = 1'b0;
    bit hold_req     = 1'b0;
    bit signed_now   = 1'b0;

    packed_bcd_to_digit_chars_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .bcd_word  (bcd_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

    packed_bcd_to_digit_chars_checker char_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bcd_word      (bcd_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .char_code     (char_code),
        .last_char     (last_char),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #6 clk = ~clk;

    function automatic int next_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [pbcd_pkg::IN_W-1:0] rand_word();
        logic [pbcd_pkg::IN_W-1:0] w;
        int                        sel;
        int                        nb;
        int                        n;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return {$urandom, $urandom};
        if (sel < 19)
            return '0;
        w  = '0;
        nb = $urandom_range(1, 8);
        for (n = 0; n < 2 * nb; n++) begin
            if ($urandom_range(0, 9) != 0)
                w[4*n +: 4] = 4'($urandom_range(0, 9));
            else
                w[4*n +: 4] = 4'($urandom_range(10, 15));
        end
        case ($urandom_range(0, 3))
            0:       w[8*nb-1 -: 4] = 4'h0;
            1:       w[8*nb-1 -: 4] = pbcd_pkg::SIGN_NIB;
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [pbcd_pkg::IN_W-1:0] w, input int gap);
        @(negedge clk);
        in_valid <= 1'b1;
        bcd_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (signed_now)
            signed_words++;
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic v);
        wait_drain();
        cfg_we     <= 1'b1;
        cfg_wdata  <= v;
        signed_now = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(64'h0000_0000_0000_0000, next_gap());
        send_word(64'h0000_0000_0000_0001, next_gap());
        send_word(64'h0000_0000_0000_0009, next_gap());
        send_word(64'h0000_0000_0000_0010, next_gap());
        send_word(64'h0000_0000_0000_000A, next_gap());
        send_word(64'h0000_0000_0000_0F00, next_gap());
        send_word(64'h0000_0000_0000_0100, next_gap());
        send_word(64'h0000_0000_0000_00F1, next_gap());
        send_word(64'h0000_0000_0000_00F0, next_gap());
        send_word(64'h0000_0000_0000_F000, next_gap());
        send_word(64'h0123_4567_89AB_CDEF, next_gap());
        send_word(64'h9999_9999_9999_9999, next_gap());
        send_word(64'hFFFF_FFFF_FFFF_FFFF, next_gap());
        send_word(64'hF000_0000_0000_0000, next_gap());
        send_word(64'h8000_0000_0000_0000, next_gap());
        send_word(64'h0F12_3456_7890_1234, next_gap());
        send_word(64'h5500_0000_0000_0000, next_gap());
        send_word(64'h0000_0000_00FA_BC00, next_gap());
    endtask

    task automatic run_random(input int count, input bit hold);
        int i;
        for (i = 0; i < count; i++) begin
            if (hold && i == 0)
                hold_req = 1'b1;
            if (i == count / 2)
                wait_drain();
            send_word(rand_word(), (hold && i < 30) ? 0 : next_gap());
        end
    endtask

    initial begin
        int idle_left;
        idle_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_left > 0 && !quiet) begin
                out_ready <= 1'b0;
                idle_left--;
            end
            else begin
                out_ready <= 1'b1;
                idle_left = 0;
                if ($urandom_range(0, 99) < 15)
                    idle_left = next_gap();
            end
        end
    end

    initial begin
        while (cycles < MAX_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        write_mode(1'b1);
        run_directed();
        run_random(140, 1'b1);
        write_mode(1'b0);
        quiet = 1'b1;
        run_random(70, 1'b0);
        quiet = 1'b0;
        run_random(70, 1'b0);
        write_mode(1'b1);
        run_random(140, 1'b0);

        wait_drain();
        repeat (40) @(negedge clk);
        $display("Ran %0d words (%0d in signed mode), %0d characters checked,",
                 words_sent, signed_words, checked_count);
        $display("with random gaps, a long receiver hold-off and drain pauses.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
sv/pbcd_pkg.sv
sv/pbcd_shifter.sv
sv/pbcd_ctrl.sv
sv/packed_bcd_to_digit_chars_core.sv
sv/pbcd_checker.sv
dv/packed_bcd_to_digit_chars_checker.sv
dv/packed_bcd_to_digit_chars_core_tb.sv
